FILE: sv/ssit_pkg.sv
`timescale 1ns / 1ps
package ssit_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int ID_COUNT   = 64;
	localparam int ID_SHIFT   = 16;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int QS_W       = SLOT_W + 1;
	localparam int ID_W       = $clog2(ID_COUNT);
	localparam int GRP        = 8;
	localparam int GRP_W      = $clog2(GRP);
	localparam int NGRP       = ID_COUNT / GRP;
	localparam int NGRP_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int CNT_W      = $clog2(QS_W + 1);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NOID = 2'd2
	} status_t;

	typedef struct packed {
		logic        func;
		logic [31:0] command_word0;
		logic [11:0] slot;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] slot_taken;
		logic [5:0]  command_id;
		logic [31:0] stamped_word0;
		logic [11:0] tail_doorbell;
		logic [11:0] head_now;
		logic        phase_now;
	} out_word_t;

	// ring size clamped to the legal range
	function automatic logic [QS_W-1:0] eff_size(input logic [12:0] rs);
		logic [QS_W-1:0] s;
		s = QS_W'(rs);
		if (rs < 13'd2) s = QS_W'(2);
		if (rs > 13'(RING_DEPTH)) s = QS_W'(RING_DEPTH);
		return s;
	endfunction

endpackage

FILE: sv/ssit_rem.sv
`timescale 1ns / 1ps
// restoring remainder, one quotient bit a cycle
module ssit_rem import ssit_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [QS_W-1:0] num,
	input  logic [QS_W-1:0] den,
	output logic            done,
	output logic [QS_W-1:0] rem
);

	logic [QS_W-1:0] num_q;
	logic [QS_W-1:0] den_q;
	logic [QS_W:0]   r_q;
	logic [CNT_W-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [QS_W:0]   r_sh;

	assign r_sh = {r_q[QS_W-1:0], num_q[QS_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QS_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			r_q   <= '0;
		end else if (run_q) begin
			num_q <= {num_q[QS_W-2:0], 1'b0};
			if (r_sh >= {1'b0, den_q}) r_q <= r_sh - {1'b0, den_q};
			else r_q <= r_sh;
		end
	end

	assign done = done_q;
	assign rem  = r_q[QS_W-1:0];

endmodule

FILE: sv/ssit_ids.sv
`timescale 1ns / 1ps
// command id busy flags with a registered lowest-free search
module ssit_ids import ssit_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            set_en,
	input  logic [ID_W-1:0] set_id,
	input  logic            clr_en,
	input  logic [ID_W-1:0] clr_id,
	output logic            found,
	output logic [ID_W-1:0] free_id
);

	logic [ID_COUNT-1:0] busy_q;
	logic [NGRP-1:0]     gfree_s1;
	logic [GRP_W-1:0]    gidx_s1 [NGRP];
	logic [NGRP-1:0]     gfree_c;
	logic [GRP_W-1:0]    gidx_c  [NGRP];

	// per group: any free, lowest free within the group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			gfree_c[g] = 1'b0;
			gidx_c[g]  = '0;
			for (int k = GRP - 1; k >= 0; k--) begin
				if (!busy_q[g*GRP + k]) begin
					gfree_c[g] = 1'b1;
					gidx_c[g]  = GRP_W'(k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			gfree_s1 <= '0;
			for (int g = 0; g < NGRP; g++) gidx_s1[g] <= '0;
		end else begin
			if (set_en) busy_q[set_id] <= 1'b1;
			if (clr_en) busy_q[clr_id] <= 1'b0;
			gfree_s1 <= gfree_c;
			for (int g = 0; g < NGRP; g++) gidx_s1[g] <= gidx_c[g];
		end
	end

	// lowest group with a free id
	always_comb begin
		found   = 1'b0;
		free_id = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (gfree_s1[g]) begin
				found   = 1'b1;
				free_id = ID_W'((g * GRP) + int'(gidx_s1[g]));
			end
		end
	end

endmodule

FILE: sv/submission_slot_and_id_tracker_core.sv
`timescale 1ns / 1ps
// flow: an enqueue runs the modulo unit, then the finish state that registers word and strobe; an
// in-range retire runs the modulo unit, then walks the head (a read and a check state per done slot,
// up to a full lap) before finish; an out-of-range retire goes straight to finish; the done-mark port
// is shared by read and clear; one word at a time, busy drops in the strobe cycle; the modulo unit
// (one bit a cycle) sets the fixed part of every enqueue and in-range retire
// reset: pointers cleared, phase set, a pass over every done mark clears them with busy high
module submission_slot_and_id_tracker_core import ssit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    item,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	output logic        strobe,
	output out_word_t   result
);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_MOD  = 6'b000100,
		S_WRD  = 6'b001000,
		S_WCHK = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration and ring pointers
	logic [12:0]       ring_size_q;
	logic [SLOT_W-1:0] tail_q;
	logic [SLOT_W-1:0] head_q;
	logic              phase_q;

	// latched word and per-item results
	in_word_t          item_q;
	logic [1:0]        st_q;
	logic [SLOT_W-1:0] taken_q;
	logic [ID_W-1:0]   cid_q;

	// walk control
	logic [SLOT_W-1:0] l_q;
	logic [QS_W-1:0]   cnt_q;
	logic [SLOT_W-1:0] clr_q;

	// output register
	out_word_t         res_q;
	logic              strobe_q;

	// memories: done marks and recorded ids
	logic              done_mem [RING_DEPTH];
	logic [ID_W-1:0]   id_mem   [RING_DEPTH];
	logic              done_rd_q;
	logic [ID_W-1:0]   id_rd_q;

	logic              dm_we;
	logic [SLOT_W-1:0] dm_addr;
	logic              dm_wd;
	logic              dm_re;

	logic [QS_W-1:0]   qs;
	logic              accept;
	logic [QS_W-1:0]   occupied;
	logic [QS_W-1:0]   tail_n;
	logic [QS_W-1:0]   head_n;
	logic [QS_W-1:0]   l_n;

	// modulo unit
	logic              rem_go;
	logic [QS_W-1:0]   rem_num;
	logic              rem_done;
	logic [QS_W-1:0]   rem_val;

	// id allocator
	logic              id_set;
	logic              id_clr;
	logic              id_found;
	logic [ID_W-1:0]   id_free;
	logic              enq_commit;

	assign qs     = eff_size(ring_size_q);
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// distance tail - head, wrapped by the ring size when the tail is behind
	assign occupied = (tail_q >= head_q) ? QS_W'(tail_q - head_q)
	                                     : QS_W'({1'b0, tail_q} + qs - {1'b0, head_q});
	assign tail_n = {1'b0, tail_q} + 1'b1;
	assign head_n = {1'b0, head_q} + 1'b1;
	assign l_n    = {1'b0, l_q} + 1'b1;

	// enqueue: modulo of the distance; retire of an in-range slot: old head modulo size
	assign rem_go  = accept && (!item.func || (QS_W'(item.slot) < qs));
	assign rem_num = item.func ? QS_W'(head_q) : occupied;

	ssit_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (rem_go),
		.num    (rem_num),
		.den    (qs),
		.done   (rem_done),
		.rem    (rem_val)
	);

	// commit an enqueue when not full and an id is free
	assign enq_commit = (state_q == S_MOD) && rem_done && !item_q.func
	                    && (rem_val != qs - 1'b1) && id_found;
	assign id_set = enq_commit;
	assign id_clr = (state_q == S_MOD) && rem_done && item_q.func;

	ssit_ids u_ids (
		.clk     (clk),
		.arst_n  (arst_n),
		.set_en  (id_set),
		.set_id  (id_free),
		.clr_en  (id_clr),
		.clr_id  (id_rd_q),
		.found   (id_found),
		.free_id (id_free)
	);

	// done-mark port: clear pass, set on retire, clear while walking
	always_comb begin
		dm_we   = 1'b0;
		dm_addr = l_q;
		dm_wd   = 1'b0;
		dm_re   = 1'b0;
		unique case (state_q)
			S_CLR: begin
				dm_we   = 1'b1;
				dm_addr = clr_q;
			end
			S_IDLE: begin
				dm_we   = rem_go && item.func;
				dm_addr = item.slot;
				dm_wd   = 1'b1;
			end
			S_WRD: begin
				dm_re = (cnt_q < qs);
			end
			S_WCHK: begin
				dm_we = done_rd_q;
			end
			default: begin
				dm_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dm_we) done_mem[dm_addr] <= dm_wd;
		if (dm_re) done_rd_q <= done_mem[l_q];
	end

	// recorded ids: read at retire accept, written on enqueue commit
	always_ff @(posedge clk) begin
		if (enq_commit) id_mem[tail_q] <= id_free;
		if (accept && item.func) id_rd_q <= id_mem[item.slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ring_size_q <= 13'(RING_DEPTH);
			tail_q      <= '0;
			head_q      <= '0;
			phase_q     <= 1'b1;
			clr_q       <= '0;
			cnt_q       <= '0;
			l_q         <= '0;
			st_q        <= ST_OK;
			taken_q     <= '0;
			cid_q       <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) ring_size_q <= cfg_wdata;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(RING_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						st_q    <= ST_OK;
						taken_q <= '0;
						cid_q   <= '0;
						// out-of-range retire changes nothing
						state_q <= rem_go ? S_MOD : S_FIN;
					end
				end
				S_MOD: begin
					if (rem_done) begin
						if (item_q.func) begin
							l_q     <= rem_val[SLOT_W-1:0];
							cnt_q   <= '0;
							state_q <= S_WRD;
						end else begin
							state_q <= S_FIN;
							if (rem_val == qs - 1'b1) begin
								st_q <= ST_FULL;
							end else if (!id_found) begin
								st_q <= ST_NOID;
							end else begin
								taken_q <= tail_q;
								cid_q   <= id_free;
								tail_q  <= (tail_n >= qs) ? '0 : tail_n[SLOT_W-1:0];
							end
						end
					end
				end
				S_WRD: begin
					// walk stops after a full lap
					state_q <= (cnt_q < qs) ? S_WCHK : S_FIN;
				end
				S_WCHK: begin
					if (done_rd_q) begin
						cnt_q <= cnt_q + 1'b1;
						l_q   <= (l_n >= qs) ? '0 : l_n[SLOT_W-1:0];
						if (head_n >= qs) begin
							head_q  <= '0;
							phase_q <= ~phase_q;
						end else begin
							head_q <= head_n[SLOT_W-1:0];
						end
						state_q <= S_WRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// latched word and the output register
	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (state_q == S_FIN) begin
			res_q.status        <= st_q;
			res_q.slot_taken    <= taken_q;
			res_q.command_id    <= cid_q;
			res_q.stamped_word0 <= (st_q == ST_OK && !item_q.func)
			                       ? (item_q.command_word0 | (32'(cid_q) << ID_SHIFT))
			                       : 32'd0;
			res_q.tail_doorbell <= tail_q;
			res_q.head_now      <= head_q;
			res_q.phase_now     <= phase_q;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

FILE: tb/sv/submission_slot_and_id_tracker_core_test.sv
`timescale 1ns / 1ps
module submission_slot_and_id_tracker_core_test;
	import ssit_pkg::*;

	// cycle budget: the clearing pass after reset, then about 550 words, each with its processing,
	// its walked slots and a random idle gap before it, times a margin
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int PHASE_WORDS  = 40;
	localparam int TAIL_CYCLES  = 40;
	localparam int PLAN_ROWS    = 31;

	typedef enum bit {FN_ENQ = 1'b0, FN_RETIRE = 1'b1} fn_t;
	typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		fn_t         fn;
		logic [31:0] w;
		logic [11:0] s;
		bit          typed;
		out_word_t   want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    item;
	logic        cfg_we;
	logic [12:0] cfg_wdata;
	logic        strobe;
	out_word_t   result;

	submission_slot_and_id_tracker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.result    (result)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// shadow copy of the ring tracker
	logic [12:0] sh_ring_size;
	int          sh_tail;
	int          sh_head;
	bit          sh_phase;
	bit          sh_done    [RING_DEPTH];
	int          sh_slot_id [RING_DEPTH];
	bit          sh_written [RING_DEPTH];
	bit          sh_id_busy [ID_COUNT];

	out_word_t   pending_words [$];
	int          open_slots [$];
	int          fail_count;
	int          cycle_count;

	// ring size actually used by the block
	function automatic int ring_span();
		int s;
		s = int'(sh_ring_size);
		if (s < 2) s = 2;
		if (s > RING_DEPTH) s = RING_DEPTH;
		return s;
	endfunction

	// advance the shadow state by one word and return the word the block should give
	function automatic out_word_t track_step(input in_word_t w);
		out_word_t r;
		int qs;
		int occupied;
		int cid;
		int walk_base;
		int l;
		qs = ring_span();
		r = '0;
		r.status = ST_OK;
		if (w.func == FN_ENQ) begin
			occupied = (sh_tail >= sh_head) ? sh_tail - sh_head : sh_tail + qs - sh_head;
			if (occupied % qs == qs - 1) begin
				r.status = ST_FULL;
			end else begin
				cid = -1;
				for (int i = 0; i < ID_COUNT; i++) begin
					if (!sh_id_busy[i] && cid < 0) cid = i;
				end
				if (cid < 0) begin
					r.status = ST_NOID;
				end else begin
					sh_id_busy[cid] = 1'b1;
					r.slot_taken = 12'(sh_tail);
					r.command_id = 6'(cid);
					r.stamped_word0 = w.command_word0 | (32'(cid) << ID_SHIFT);
					sh_slot_id[sh_tail] = cid;
					sh_written[sh_tail] = 1'b1;
					sh_tail = (sh_tail + 1 >= qs) ? 0 : sh_tail + 1;
				end
			end
		end else if (int'(w.slot) < qs) begin
			sh_id_busy[sh_slot_id[w.slot]] = 1'b0;
			sh_done[w.slot] = 1'b1;
			walk_base = sh_head;
			// head walks over the run of done slots, phase flips on each wrap
			for (int i = 0; i < qs; i++) begin
				l = (walk_base + i) % qs;
				if (!sh_done[l]) break;
				sh_done[l] = 1'b0;
				if (sh_head + 1 >= qs) begin
					sh_head = 0;
					sh_phase = ~sh_phase;
				end else begin
					sh_head = sh_head + 1;
				end
			end
		end
		r.tail_doorbell = 12'(sh_tail);
		r.head_now = 12'(sh_head);
		r.phase_now = sh_phase;
		return r;
	endfunction

	// present one word after a random gap and hold it until the block takes it
	task automatic issue_word(input in_word_t w, input bit typed, input out_word_t want);
		int gap;
		out_word_t predicted;
		gap = $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		predicted = track_step(w);
		pending_words.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// register write only once everything in flight has come back
	task automatic write_ring_size(input logic [12:0] v);
		start <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_ring_size = v;
	endtask

	task automatic retire_slot(input int s);
		in_word_t w;
		w.func = FN_RETIRE;
		w.command_word0 = $urandom();
		w.slot = 12'(s);
		for (int i = 0; i < open_slots.size(); i++) begin
			if (open_slots[i] == s) begin
				open_slots.delete(i);
				break;
			end
		end
		issue_word(w, 1'b0, '0);
	endtask

	// compare each strobed word with the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h", $time, result);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (result.status !== want.status) begin
					$display("%0t status: expected %0d, actual %0d", $time, want.status,
						result.status);
					fail_count++;
				end
				if (result.slot_taken !== want.slot_taken) begin
					$display("%0t slot_taken: expected %0d, actual %0d", $time,
						want.slot_taken, result.slot_taken);
					fail_count++;
				end
				if (result.command_id !== want.command_id) begin
					$display("%0t command_id: expected %0d, actual %0d", $time,
						want.command_id, result.command_id);
					fail_count++;
				end
				if (result.stamped_word0 !== want.stamped_word0) begin
					$display("%0t stamped_word0: expected %h, actual %h", $time,
						want.stamped_word0, result.stamped_word0);
					fail_count++;
				end
				if (result.tail_doorbell !== want.tail_doorbell) begin
					$display("%0t tail_doorbell: expected %0d, actual %0d", $time,
						want.tail_doorbell, result.tail_doorbell);
					fail_count++;
				end
				if (result.head_now !== want.head_now) begin
					$display("%0t head_now: expected %0d, actual %0d", $time,
						want.head_now, result.head_now);
					fail_count++;
				end
				if (result.phase_now !== want.phase_now) begin
					$display("%0t phase_now: expected %0d, actual %0d", $time,
						want.phase_now, result.phase_now);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// directed plan: typed rows are the ones readable straight after reset
	row_t plan [PLAN_ROWS] = '{
		'{ROW_CFG,  FN_ENQ,    32'd4096,     12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h00000000, 12'd0,    1'b1,
			'{ST_OK, 12'd0, 6'd0, 32'h00000000, 12'd1, 12'd0, 1'b1}},
		'{ROW_WORD, FN_ENQ,    32'hFFFFFFFF, 12'd0,    1'b1,
			'{ST_OK, 12'd1, 6'd1, 32'hFFFFFFFF, 12'd2, 12'd0, 1'b1}},
		// out-of-order retire leaves the head in place
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd1,    1'b1,
			'{ST_OK, 12'd0, 6'd0, 32'h00000000, 12'd2, 12'd0, 1'b1}},
		// head walks over both done slots
		'{ROW_WORD, FN_RETIRE, 32'hFFFFFFFF, 12'd0,    1'b1,
			'{ST_OK, 12'd0, 6'd0, 32'h00000000, 12'd2, 12'd2, 1'b1}},
		'{ROW_WORD, FN_ENQ,    32'h0000FFFF, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h12345678, 12'd0,    1'b0, '0},
		// smallest ring, pointers left beyond its end
		'{ROW_CFG,  FN_ENQ,    32'd2,        12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'hAAAAAAAA, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h55555555, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'hFFF,  1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd2,    1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd1,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h0F0F0F0F, 12'd0,    1'b0, '0},
		// below the minimum, acts as two slots
		'{ROW_CFG,  FN_ENQ,    32'd0,        12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'hF0F0F0F0, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h00010000, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd1,    1'b0, '0},
		// above the maximum, acts as the full depth
		'{ROW_CFG,  FN_ENQ,    32'd8191,     12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h80000000, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h7FFFFFFF, 12'd0,    1'b0, '0},
		// five slots: the fourth and fifth enqueues hit the full ring
		'{ROW_CFG,  FN_ENQ,    32'd5,        12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h00000001, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h00000002, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h00000003, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h00000004, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_ENQ,    32'h00000005, 12'd0,    1'b0, '0},
		'{ROW_WORD, FN_RETIRE, 32'h00000000, 12'd1,    1'b0, '0}
	};

	// ring sizes for the random phases
	int phase_sizes [10] = '{4096, 3, 100, 2, 8191, 70, 1, 17, 4096, 200};

	initial begin
		in_word_t w;
		out_word_t r;
		int enq_pct;
		int qs;
		int s;
		int tries;
		fail_count = 0;
		cycle_count = 0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sh_ring_size = 13'd4096;
		sh_tail = 0;
		sh_head = 0;
		sh_phase = 1'b1;
		for (int i = 0; i < RING_DEPTH; i++) begin
			sh_done[i] = 1'b0;
			sh_slot_id[i] = 0;
			sh_written[i] = 1'b0;
		end
		for (int i = 0; i < ID_COUNT; i++) sh_id_busy[i] = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed part
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].kind == ROW_CFG) begin
				write_ring_size(plan[i].w[12:0]);
			end else begin
				w.func = plan[i].fn;
				w.command_word0 = plan[i].w;
				w.slot = plan[i].s;
				issue_word(w, plan[i].typed, plan[i].want);
			end
		end

		// random phases: mostly enqueues and retires of live slots, some noise
		foreach (phase_sizes[p]) begin
			write_ring_size(13'(phase_sizes[p]));
			open_slots.delete();
			qs = ring_span();
			enq_pct = (qs > 64 && $urandom_range(0, 1)) ? 92 : $urandom_range(40, 85);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(0, 99) < 12) begin
					// noise: retire any slot that is legal to touch
					s = -1;
					tries = 0;
					while (s < 0 && tries < 50) begin
						s = $urandom_range(0, RING_DEPTH - 1);
						if (s < qs && !sh_written[s]) s = -1;
						tries++;
					end
					if (s < 0) s = RING_DEPTH - 1 >= qs ? RING_DEPTH - 1 : 0;
					retire_slot(s);
				end else if (open_slots.size() > 0 &&
					($urandom_range(0, 99) >= enq_pct || open_slots.size() >= qs - 1)) begin
					retire_slot(open_slots[$urandom_range(0, open_slots.size() - 1)]);
				end else begin
					w.func = FN_ENQ;
					w.command_word0 = $urandom();
					w.slot = 12'($urandom());
					s = sh_tail;
					issue_word(w, 1'b0, '0);
					r = pending_words[$];
					if (r.status == ST_OK) open_slots.push_back(s);
				end
			end
			// drain the phase so no ID stays tied to a slot the next size hides
			while (open_slots.size() > 0)
				retire_slot(open_slots[$urandom_range(0, open_slots.size() - 1)]);
		end

		start <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
